// ===== src/dgbe_pkg.sv =====
`timescale 1ns / 1ps

package dgbe_pkg;

   // Field widths fixed by the item formats
   localparam int PROB_W      = 16;
   localparam int CLASS_W     = 6;
   localparam int OFFSET_W    = 23;
   localparam int CLASS_SPAN  = 2 ** CLASS_W;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   // Defaults for the top-level parameters
   localparam int DEF_COORD_WIDTH = 24;
   localparam int DEF_CLASS_COUNT = 64;

   // Register values after reset
   localparam logic [PROB_W-1:0]   RST_MIN_PROB      = 16'd19661;
   localparam logic [OFFSET_W-1:0] RST_MAX_X_OFF     = 23'd1229;
   localparam logic [OFFSET_W-1:0] RST_MAX_DEPTH_OFF = 23'd410;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_PROB      = 2'd0,
      REG_CLASS_MASK    = 2'd1,
      REG_MAX_X_OFF     = 2'd2,
      REG_MAX_DEPTH_OFF = 2'd3
   } csr_index_type;

   // Item kinds on the request channel
   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_POINT  = 1'b1
   } op_type;

endpackage

// ===== src/dgbe_if.sv =====
`timescale 1ns / 1ps

interface dgbe_req_if import dgbe_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [PROB_W-1:0]             probability;
   logic [CLASS_W-1:0]            class_index;
   logic signed [COORD_WIDTH-1:0] px;
   logic signed [COORD_WIDTH-1:0] py;
   logic signed [COORD_WIDTH-1:0] pz;
   logic                          point_valid;
   logic                          last;

   modport source (
      output valid, op, probability, class_index, px, py, pz, point_valid, last,
      input  ready
   );
   modport sink (
      input  valid, op, probability, class_index, px, py, pz, point_valid, last,
      output ready
   );
endinterface

interface dgbe_rsp_if import dgbe_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic [CLASS_W-1:0]            out_class;
   logic [PROB_W-1:0]             out_probability;
   logic signed [COORD_WIDTH-1:0] x_low;
   logic signed [COORD_WIDTH-1:0] x_high;
   logic signed [COORD_WIDTH-1:0] y_low;
   logic signed [COORD_WIDTH-1:0] y_high;
   logic signed [COORD_WIDTH-1:0] z_low;
   logic signed [COORD_WIDTH-1:0] z_high;
   logic                          empty_res;

   modport source (
      output valid, out_class, out_probability, x_low, x_high, y_low, y_high,
             z_low, z_high, empty_res,
      input  ready
   );
   modport sink (
      input  valid, out_class, out_probability, x_low, x_high, y_low, y_high,
             z_low, z_high, empty_res,
      output ready
   );
endinterface

// ===== src/dgbe_csr.sv =====
`timescale 1ns / 1ps

module dgbe_csr import dgbe_pkg::*; #(
   parameter int CLASS_COUNT = DEF_CLASS_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [PROB_W-1:0]      min_prob,
   output logic [CLASS_COUNT-1:0] class_mask,
   output logic [OFFSET_W-1:0]    max_x_off,
   output logic [OFFSET_W-1:0]    max_depth_off
);

   logic [PROB_W-1:0]      min_prob_ff,      min_prob_in;
   logic [CLASS_COUNT-1:0] class_mask_ff,    class_mask_in;
   logic [OFFSET_W-1:0]    max_x_off_ff,     max_x_off_in;
   logic [OFFSET_W-1:0]    max_depth_off_ff, max_depth_off_in;

   // Decode the write; bits above a register's width drop
   always_comb begin
      min_prob_in      = min_prob_ff;
      class_mask_in    = class_mask_ff;
      max_x_off_in     = max_x_off_ff;
      max_depth_off_in = max_depth_off_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_MIN_PROB:      min_prob_in      = csr_data[PROB_W-1:0];
            REG_CLASS_MASK:    class_mask_in    = csr_data[CLASS_COUNT-1:0];
            REG_MAX_X_OFF:     max_x_off_in     = csr_data[OFFSET_W-1:0];
            REG_MAX_DEPTH_OFF: max_depth_off_in = csr_data[OFFSET_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_prob_ff      <= RST_MIN_PROB;
         class_mask_ff    <= '0;
         max_x_off_ff     <= RST_MAX_X_OFF;
         max_depth_off_ff <= RST_MAX_DEPTH_OFF;
      end else begin
         min_prob_ff      <= min_prob_in;
         class_mask_ff    <= class_mask_in;
         max_x_off_ff     <= max_x_off_in;
         max_depth_off_ff <= max_depth_off_in;
      end
   end

   assign min_prob      = min_prob_ff;
   assign class_mask    = class_mask_ff;
   assign max_x_off     = max_x_off_ff;
   assign max_depth_off = max_depth_off_ff;

endmodule

// ===== src/dgbe_extent.sv =====
`timescale 1ns / 1ps

module dgbe_extent import dgbe_pkg::*; #(
   parameter int CLASS_COUNT = DEF_CLASS_COUNT,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // settings
   input  logic [PROB_W-1:0]             min_prob,
   input  logic [CLASS_COUNT-1:0]        class_mask,
   input  logic [OFFSET_W-1:0]           max_x_off,
   input  logic [OFFSET_W-1:0]           max_depth_off,
   // item in the input register, consumed when fire is high
   input  logic                          fire,
   input  logic                          item_op,
   input  logic [PROB_W-1:0]             item_prob,
   input  logic [CLASS_W-1:0]            item_class,
   input  logic signed [COORD_WIDTH-1:0] item_px,
   input  logic signed [COORD_WIDTH-1:0] item_py,
   input  logic signed [COORD_WIDTH-1:0] item_pz,
   input  logic                          item_valid,
   input  logic                          item_last,
   // result the item closes, if any
   output logic                          emit,
   output logic [CLASS_W-1:0]            res_class,
   output logic [PROB_W-1:0]             res_prob,
   output logic signed [COORD_WIDTH-1:0] res_x_low,
   output logic signed [COORD_WIDTH-1:0] res_x_high,
   output logic signed [COORD_WIDTH-1:0] res_y_low,
   output logic signed [COORD_WIDTH-1:0] res_y_high,
   output logic signed [COORD_WIDTH-1:0] res_z_low,
   output logic signed [COORD_WIDTH-1:0] res_z_high,
   output logic                          res_empty
);

   localparam int DIFF_W = (COORD_WIDTH + 1 > OFFSET_W) ? COORD_WIDTH + 1 : OFFSET_W;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
      $signed({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN =
      $signed({1'b1, {(COORD_WIDTH-1){1'b0}}});

   logic                          box_accepted_ff, box_accepted_in;
   logic                          any_kept_ff,     any_kept_in;
   logic signed [COORD_WIDTH-1:0] centre_x_ff,     centre_x_in;
   logic signed [COORD_WIDTH-1:0] centre_z_ff,     centre_z_in;
   logic [CLASS_W-1:0]            held_class_ff,   held_class_in;
   logic [PROB_W-1:0]             held_prob_ff,    held_prob_in;
   logic signed [COORD_WIDTH-1:0] x_low_ff,  x_low_in,  x_low_nx;
   logic signed [COORD_WIDTH-1:0] x_high_ff, x_high_in, x_high_nx;
   logic signed [COORD_WIDTH-1:0] y_low_ff,  y_low_in,  y_low_nx;
   logic signed [COORD_WIDTH-1:0] y_high_ff, y_high_in, y_high_nx;
   logic signed [COORD_WIDTH-1:0] z_low_ff,  z_low_in,  z_low_nx;
   logic signed [COORD_WIDTH-1:0] z_high_ff, z_high_in, z_high_nx;

   logic [CLASS_SPAN-1:0]    mask_ext;
   logic                     is_header;
   logic                     header_ok;
   logic signed [DIFF_W-1:0] dx, dz;
   logic [DIFF_W-1:0]        adx, adz;
   logic                     keep;
   logic                     any_now;

   // Judge the header: probability, class of interest, centre valid
   assign mask_ext  = CLASS_SPAN'(class_mask);
   assign is_header = (item_op == OP_HEADER);
   assign header_ok = (item_prob >= min_prob) && mask_ext[item_class] && item_valid;

   // Gate the point on its distance from the centre
   assign dx   = DIFF_W'(item_px) - DIFF_W'(centre_x_ff);
   assign dz   = DIFF_W'(item_pz) - DIFF_W'(centre_z_ff);
   assign adx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign adz  = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
   assign keep = !is_header && box_accepted_ff && item_valid &&
                 (adz <= DIFF_W'(max_depth_off)) && (adx <= DIFF_W'(max_x_off));

   // Extents with this point folded in
   always_comb begin
      x_low_nx  = x_low_ff;
      x_high_nx = x_high_ff;
      y_low_nx  = y_low_ff;
      y_high_nx = y_high_ff;
      z_low_nx  = z_low_ff;
      z_high_nx = z_high_ff;
      if (keep) begin
         if (item_px < x_low_ff)  x_low_nx  = item_px;
         if (item_px > x_high_ff) x_high_nx = item_px;
         if (item_py < y_low_ff)  y_low_nx  = item_py;
         if (item_py > y_high_ff) y_high_nx = item_py;
         if (item_pz < z_low_ff)  z_low_nx  = item_pz;
         if (item_pz > z_high_ff) z_high_nx = item_pz;
      end
   end

   assign any_now = any_kept_ff || keep;
   assign emit    = !is_header && box_accepted_ff && item_last;

   // Result fields; an empty box reports zero extents
   assign res_class  = held_class_ff;
   assign res_prob   = held_prob_ff;
   assign res_empty  = !any_now;
   assign res_x_low  = any_now ? x_low_nx  : '0;
   assign res_x_high = any_now ? x_high_nx : '0;
   assign res_y_low  = any_now ? y_low_nx  : '0;
   assign res_y_high = any_now ? y_high_nx : '0;
   assign res_z_low  = any_now ? z_low_nx  : '0;
   assign res_z_high = any_now ? z_high_nx : '0;

   // Advance the box state when the item is consumed
   always_comb begin
      box_accepted_in = box_accepted_ff;
      any_kept_in     = any_kept_ff;
      centre_x_in     = centre_x_ff;
      centre_z_in     = centre_z_ff;
      held_class_in   = held_class_ff;
      held_prob_in    = held_prob_ff;
      x_low_in        = x_low_ff;
      x_high_in       = x_high_ff;
      y_low_in        = y_low_ff;
      y_high_in       = y_high_ff;
      z_low_in        = z_low_ff;
      z_high_in       = z_high_ff;
      if (fire) begin
         if (is_header || emit) begin
            // open a new box or close the current one: clear extents
            box_accepted_in = is_header && header_ok;
            any_kept_in     = 1'b0;
            x_low_in        = COORD_MAX;
            x_high_in       = COORD_MIN;
            y_low_in        = COORD_MAX;
            y_high_in       = COORD_MIN;
            z_low_in        = COORD_MAX;
            z_high_in       = COORD_MIN;
            if (is_header && header_ok) begin
               centre_x_in   = item_px;
               centre_z_in   = item_pz;
               held_class_in = item_class;
               held_prob_in  = item_prob;
            end
         end else begin
            any_kept_in = any_now;
            x_low_in    = x_low_nx;
            x_high_in   = x_high_nx;
            y_low_in    = y_low_nx;
            y_high_in   = y_high_nx;
            z_low_in    = z_low_nx;
            z_high_in   = z_high_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_accepted_ff <= 1'b0;
         any_kept_ff     <= 1'b0;
      end else begin
         box_accepted_ff <= box_accepted_in;
         any_kept_ff     <= any_kept_in;
      end
   end

   // Payload state; an accepted header loads it before it is read
   always_ff @(posedge clock) begin
      centre_x_ff   <= centre_x_in;
      centre_z_ff   <= centre_z_in;
      held_class_ff <= held_class_in;
      held_prob_ff  <= held_prob_in;
      x_low_ff      <= x_low_in;
      x_high_ff     <= x_high_in;
      y_low_ff      <= y_low_in;
      y_high_ff     <= y_high_in;
      z_low_ff      <= z_low_in;
      z_high_ff     <= z_high_in;
   end

endmodule

// ===== src/depth_gated_box_extent_top.sv =====
`timescale 1ns / 1ps

// Channel    Dir   Handshake      Contents
// req_chan   in    valid/ready    header (probability, class, centre) or region point
// rsp_chan   out   valid/ready    class, probability, x/y/z extents, empty flag
// csr_*      in    write enable   min probability, class mask, x and depth offsets
//
// One item per cycle unless a closing point stalls: the input register feeds
// the gate and min/max update, which lands in the extent registers, and for a
// closing point in the result register that drives rsp_chan.valid.
// Reset is synchronous; it loads the register defaults and closes any open box.
// req_chan.ready falls only while a closing point waits on a full, unread
// result register.

module depth_gated_box_extent_top import dgbe_pkg::*; #(
   parameter int CLASS_COUNT = DEF_CLASS_COUNT,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   dgbe_req_if.sink               req_chan,
   dgbe_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PROB_W-1:0]      min_prob;
   logic [CLASS_COUNT-1:0] class_mask;
   logic [OFFSET_W-1:0]    max_x_off;
   logic [OFFSET_W-1:0]    max_depth_off;

   logic                          in_valid_ff,  in_valid_in;
   logic                          in_op_ff;
   logic [PROB_W-1:0]             in_prob_ff;
   logic [CLASS_W-1:0]            in_class_ff;
   logic signed [COORD_WIDTH-1:0] in_px_ff, in_py_ff, in_pz_ff;
   logic                          in_pvalid_ff;
   logic                          in_last_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]            rsp_class_ff;
   logic [PROB_W-1:0]             rsp_prob_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_low_ff, rsp_x_high_ff;
   logic signed [COORD_WIDTH-1:0] rsp_y_low_ff, rsp_y_high_ff;
   logic signed [COORD_WIDTH-1:0] rsp_z_low_ff, rsp_z_high_ff;
   logic                          rsp_empty_ff;

   logic                          emit;
   logic [CLASS_W-1:0]            res_class;
   logic [PROB_W-1:0]             res_prob;
   logic signed [COORD_WIDTH-1:0] res_x_low, res_x_high;
   logic signed [COORD_WIDTH-1:0] res_y_low, res_y_high;
   logic signed [COORD_WIDTH-1:0] res_z_low, res_z_high;
   logic                          res_empty;

   logic out_free;
   logic fire;
   logic take;

   dgbe_csr #(
      .CLASS_COUNT (CLASS_COUNT)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .min_prob      (min_prob),
      .class_mask    (class_mask),
      .max_x_off     (max_x_off),
      .max_depth_off (max_depth_off)
   );

   dgbe_extent #(
      .CLASS_COUNT (CLASS_COUNT),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_extent (
      .clock         (clock),
      .reset         (reset),
      .min_prob      (min_prob),
      .class_mask    (class_mask),
      .max_x_off     (max_x_off),
      .max_depth_off (max_depth_off),
      .fire          (fire),
      .item_op       (in_op_ff),
      .item_prob     (in_prob_ff),
      .item_class    (in_class_ff),
      .item_px       (in_px_ff),
      .item_py       (in_py_ff),
      .item_pz       (in_pz_ff),
      .item_valid    (in_pvalid_ff),
      .item_last     (in_last_ff),
      .emit          (emit),
      .res_class     (res_class),
      .res_prob      (res_prob),
      .res_x_low     (res_x_low),
      .res_x_high    (res_x_high),
      .res_y_low     (res_y_low),
      .res_y_high    (res_y_high),
      .res_z_low     (res_z_low),
      .res_z_high    (res_z_high),
      .res_empty     (res_empty)
   );

   // Consume the held item unless its result has nowhere to go
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && (!emit || out_free);
   assign req_chan.ready = !in_valid_ff || fire;
   assign take           = req_chan.valid && req_chan.ready;

   assign in_valid_in = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff     <= req_chan.op;
         in_prob_ff   <= req_chan.probability;
         in_class_ff  <= req_chan.class_index;
         in_px_ff     <= req_chan.px;
         in_py_ff     <= req_chan.py;
         in_pz_ff     <= req_chan.pz;
         in_pvalid_ff <= req_chan.point_valid;
         in_last_ff   <= req_chan.last;
      end
   end

   // Load the result register when a box closes
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_class_ff  <= res_class;
         rsp_prob_ff   <= res_prob;
         rsp_x_low_ff  <= res_x_low;
         rsp_x_high_ff <= res_x_high;
         rsp_y_low_ff  <= res_y_low;
         rsp_y_high_ff <= res_y_high;
         rsp_z_low_ff  <= res_z_low;
         rsp_z_high_ff <= res_z_high;
         rsp_empty_ff  <= res_empty;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_class       = rsp_class_ff;
   assign rsp_chan.out_probability = rsp_prob_ff;
   assign rsp_chan.x_low           = rsp_x_low_ff;
   assign rsp_chan.x_high          = rsp_x_high_ff;
   assign rsp_chan.y_low           = rsp_y_low_ff;
   assign rsp_chan.y_high          = rsp_y_high_ff;
   assign rsp_chan.z_low           = rsp_z_low_ff;
   assign rsp_chan.z_high          = rsp_z_high_ff;
   assign rsp_chan.empty_res       = rsp_empty_ff;

`ifndef SYNTHESIS
   // A closing point never overwrites an unread result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready && emit |-> !fire)
      else $error("result register overwritten");

   // A held item that is not consumed stays held
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("stalled item lost");

   // An empty box reports zero extents
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |->
         rsp_x_low_ff == '0 && rsp_x_high_ff == '0 && rsp_y_low_ff == '0 &&
         rsp_y_high_ff == '0 && rsp_z_low_ff == '0 && rsp_z_high_ff == '0)
      else $error("empty result with nonzero extents");

   // A nonempty box has ordered extents
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_empty_ff |->
         rsp_x_low_ff <= rsp_x_high_ff && rsp_y_low_ff <= rsp_y_high_ff &&
         rsp_z_low_ff <= rsp_z_high_ff)
      else $error("extents out of order");

   // A new result appears only after an item was consumed
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && emit))
      else $error("result without a closing point");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dgbe_pkg::*;

   localparam int     COORD_W     = DEF_COORD_WIDTH;
   localparam longint COORD_TOP   = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint COORD_FLOOR = -COORD_TOP - 1;
   localparam int     QUIET_LIMIT = 2000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      op_type             op;
      logic [PROB_W-1:0]  probability;
      logic [CLASS_W-1:0] class_index;
      coord_type          px;
      coord_type          py;
      coord_type          pz;
      logic               point_valid;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [PROB_W-1:0]  prob;
      coord_type          x_low;
      coord_type          x_high;
      coord_type          y_low;
      coord_type          y_high;
      coord_type          z_low;
      coord_type          z_high;
      logic               empty;
   } extent_rec_type;

   // Mirror of the gate registers and the open box; queue of extents still due
   class extent_book;
      logic [PROB_W-1:0]   min_prob;
      logic [63:0]         class_mask;
      logic [OFFSET_W-1:0] x_reach;
      logic [OFFSET_W-1:0] depth_reach;
      bit                  box_open;
      coord_type           centre_x;
      coord_type           centre_z;
      logic [CLASS_W-1:0]  held_class;
      logic [PROB_W-1:0]   held_prob;
      coord_type           lo[3];
      coord_type           hi[3];
      bit                  any_kept;
      extent_rec_type      due_extents[$];
      int                  mismatch_count;

      function new();
         min_prob       = RST_MIN_PROB;
         class_mask     = '0;
         x_reach        = RST_MAX_X_OFF;
         depth_reach    = RST_MAX_DEPTH_OFF;
         box_open       = 1'b0;
         centre_x       = '0;
         centre_z       = '0;
         held_class     = '0;
         held_prob      = '0;
         mismatch_count = 0;
         clear_extents();
      endfunction

      function void clear_extents();
         for (int k = 0; k < 3; k++) begin
            lo[k] = coord_type'(COORD_TOP);
            hi[k] = coord_type'(COORD_FLOOR);
         end
         any_kept = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_MIN_PROB:      min_prob    = data[PROB_W-1:0];
            REG_CLASS_MASK:    class_mask  = data;
            REG_MAX_X_OFF:     x_reach     = data[OFFSET_W-1:0];
            REG_MAX_DEPTH_OFF: depth_reach = data[OFFSET_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_extents.size();
      endfunction

      function longint span(coord_type a, coord_type b);
         longint d;
         d = longint'(a) - longint'(b);
         return (d < 0) ? -d : d;
      endfunction

      // Judge a header, or gate a point into the running extents
      function void take_item(req_item_type it);
         coord_type      c[3];
         extent_rec_type rec;
         if (it.op == OP_HEADER) begin
            box_open = (it.probability >= min_prob) && class_mask[it.class_index]
                       && it.point_valid;
            if (box_open) begin
               centre_x   = it.px;
               centre_z   = it.pz;
               held_class = it.class_index;
               held_prob  = it.probability;
            end
            clear_extents();
            return;
         end
         if (!box_open)
            return;
         c[0] = it.px;
         c[1] = it.py;
         c[2] = it.pz;
         if (it.point_valid && span(it.pz, centre_z) <= longint'(depth_reach)
             && span(it.px, centre_x) <= longint'(x_reach)) begin
            for (int k = 0; k < 3; k++) begin
               if (c[k] < lo[k]) lo[k] = c[k];
               if (c[k] > hi[k]) hi[k] = c[k];
            end
            any_kept = 1'b1;
         end
         if (!it.last)
            return;
         rec.cls    = held_class;
         rec.prob   = held_prob;
         rec.x_low  = any_kept ? lo[0] : '0;
         rec.x_high = any_kept ? hi[0] : '0;
         rec.y_low  = any_kept ? lo[1] : '0;
         rec.y_high = any_kept ? hi[1] : '0;
         rec.z_low  = any_kept ? lo[2] : '0;
         rec.z_high = any_kept ? hi[2] : '0;
         rec.empty  = !any_kept;
         due_extents.insert(due_extents.size(), rec);
         box_open = 1'b0;
         clear_extents();
      endfunction

      task flag_mismatch(string msg);
         mismatch_count++;
         $display("mismatch: %s", msg);
      endtask

      task compare_field(string name, longint got, longint want);
         if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      // Check one delivered extent against the oldest one due
      task match_extent(extent_rec_type got);
         extent_rec_type want;
         if (due_extents.size() == 0) begin
            flag_mismatch("extent delivered with none due");
            return;
         end
         want = due_extents.pop_front();
         compare_field("out_class", got.cls, want.cls);
         compare_field("out_probability", got.prob, want.prob);
         compare_field("x_low", got.x_low, want.x_low);
         compare_field("x_high", got.x_high, want.x_high);
         compare_field("y_low", got.y_low, want.y_low);
         compare_field("y_high", got.y_high, want.y_high);
         compare_field("z_low", got.z_low, want.z_low);
         compare_field("z_high", got.z_high, want.z_high);
         compare_field("empty_res", got.empty, want.empty);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   dgbe_req_if #(.COORD_WIDTH(COORD_W)) req ();
   dgbe_rsp_if #(.COORD_WIDTH(COORD_W)) rsp ();

   extent_book book = new();

   bit req_calm;
   bit rsp_calm;
   int live_items;
   int quiet_cycles;
   int rsp_stall;

   depth_gated_box_extent_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Observe both channels at the rising edge; watch for a stuck run
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            book.take_item(req_item_type'{op: op_type'(req.op),
                                          probability: req.probability,
                                          class_index: req.class_index, px: req.px,
                                          py: req.py, pz: req.pz,
                                          point_valid: req.point_valid, last: req.last});
         if (rsp.valid && rsp.ready)
            book.match_extent(extent_rec_type'{cls: rsp.out_class,
                                                prob: rsp.out_probability,
                                                x_low: rsp.x_low, x_high: rsp.x_high,
                                                y_low: rsp.y_low, y_high: rsp.y_high,
                                                z_low: rsp.z_low, z_high: rsp.z_high,
                                                empty: rsp.empty_res});
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles before each item
   initial begin
      rsp.ready = 1'b0;
      rsp_calm  = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm = !rsp_calm;
         rsp_stall = rsp_calm ? 0 : $urandom_range(0, 12);
         if (rsp_stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (rsp_stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Offer one item after a random gap; return at the falling edge after acceptance
   task automatic send_req(input req_item_type it);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      live_items++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.op          <= it.op;
      req.probability <= it.probability;
      req.class_index <= it.class_index;
      req.px          <= it.px;
      req.py          <= it.py;
      req.pz          <= it.pz;
      req.point_valid <= it.point_valid;
      req.last        <= it.last;
      req.valid       <= 1'b1;
      do @(posedge clock); while (req.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Hold the sender until every due extent has come back
   task automatic settle();
      req.valid <= 1'b0;
      @(negedge clock);
      while (book.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_one(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      book.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Rewrite all gate registers while idle; junk above the field width on some writes
   task automatic set_regs(input logic [PROB_W-1:0] prob, input logic [63:0] mask,
                           input logic [OFFSET_W-1:0] x_off,
                           input logic [OFFSET_W-1:0] z_off);
      logic [CSR_DATA_W-1:0] junk;
      settle();
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      write_one(REG_MIN_PROB, {junk[CSR_DATA_W-1:PROB_W], prob});
      write_one(REG_CLASS_MASK, mask);
      write_one(REG_MAX_X_OFF, {junk[CSR_DATA_W-1:OFFSET_W], x_off});
      write_one(REG_MAX_DEPTH_OFF, {junk[CSR_DATA_W-1:OFFSET_W], z_off});
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_item_type mk_item(op_type op, int prob, int cls, longint x,
                                            longint y, longint z, bit ok, bit last);
      req_item_type it;
      it.op          = op;
      it.probability = prob[PROB_W-1:0];
      it.class_index = cls[CLASS_W-1:0];
      it.px          = coord_type'(x);
      it.py          = coord_type'(y);
      it.pz          = coord_type'(z);
      it.point_valid = ok;
      it.last        = last;
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it.op          = op_type'($urandom_range(0, 1));
      it.probability = PROB_W'($urandom);
      it.class_index = CLASS_W'($urandom);
      it.px          = coord_type'($urandom);
      it.py          = coord_type'($urandom);
      it.pz          = coord_type'($urandom);
      it.point_valid = 1'($urandom_range(0, 1));
      it.last        = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Coordinate around a centre, within twice the reach plus two, sometimes exactly at it
   function automatic coord_type near_coord(coord_type c, logic [OFFSET_W-1:0] reach);
      longint r;
      longint d;
      longint v;
      r = reach;
      if ($urandom_range(0, 5) == 0)
         d = $urandom_range(0, 1) ? r : -r;
      else
         d = longint'($urandom_range(0, 32'(4 * r + 4))) - (2 * r + 2);
      v = longint'(c) + d;
      if (v > COORD_TOP) v = COORD_TOP;
      if (v < COORD_FLOOR) v = COORD_FLOOR;
      return coord_type'(v);
   endfunction

   // One detection: a mostly acceptable header, then mostly points, ending in last
   task automatic send_box();
      req_item_type it;
      coord_type    cx;
      coord_type    cz;
      int           n;
      int           pick;
      it = noise_item();
      it.op = OP_HEADER;
      it.point_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 4) != 0)
         it.probability = PROB_W'($urandom_range(int'(book.min_prob), 16'hFFFF));
      if (book.class_mask != '0 && $urandom_range(0, 4) != 0)
         repeat (64)
            if (!book.class_mask[it.class_index]) it.class_index = CLASS_W'($urandom);
      cx = it.px;
      cz = it.pz;
      send_req(it);
      n = $urandom_range(0, 8);
      for (int i = 0; i <= n; i++) begin
         it = noise_item();
         it.op = ($urandom_range(0, 29) == 0) ? OP_HEADER : OP_POINT;
         it.last = (i == n);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            it.px = near_coord(cx, book.x_reach);
            it.pz = near_coord(cz, book.depth_reach);
            it.point_valid = (pick < 6);
            if ($urandom_range(0, 1))
               it.py = coord_type'($signed($urandom_range(0, 2000)) - 1000);
         end
         send_req(it);
      end
   endtask

   task automatic run_random(input int target);
      int start;
      start = live_items;
      while (live_items - start < target) begin
         if ($urandom_range(0, 7) == 0)
            req_calm = !req_calm;
         if ($urandom_range(0, 39) == 0)
            settle();
         if ($urandom_range(0, 5) == 0)
            send_req(noise_item());
         else
            send_box();
      end
   endtask

   task automatic run_directed();
      // Equality at every gate, bad points, extreme y
      send_req(mk_item(OP_HEADER, 16'h8000, 0, 0, 0, 0, 1, 1));
      send_req(mk_item(OP_POINT, 0, 0, 100, COORD_TOP, -50, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, 101, 0, 0, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, 0, 0, 51, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, -100, COORD_FLOOR, 50, 0, 0));
      send_req(mk_item(OP_POINT, 0, 0, -100, COORD_FLOOR, 50, 1, 1));
      // Point with no box open
      send_req(mk_item(OP_POINT, 0, 0, 0, 0, 0, 1, 1));
      // Rejected headers: low probability, class off, invalid centre
      send_req(mk_item(OP_HEADER, 16'h7FFF, 1, 0, 0, 0, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, 0, 0, 0, 1, 1));
      send_req(mk_item(OP_HEADER, 16'hFFFF, 63, 0, 0, 0, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, 0, 0, 0, 1, 1));
      send_req(mk_item(OP_HEADER, 16'h8000, 2, 0, 0, 0, 0, 0));
      send_req(mk_item(OP_POINT, 0, 0, 0, 0, 0, 1, 1));
      // Empty box at the corner of the range
      send_req(mk_item(OP_HEADER, 16'hFFFF, 62, COORD_TOP, 0, COORD_FLOOR, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, COORD_TOP, 5, COORD_FLOOR, 0, 1));
      // Header while a box is open drops it
      send_req(mk_item(OP_HEADER, 16'h9000, 3, 0, 0, 0, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, 1, 1, 1, 1, 0));
      send_req(mk_item(OP_HEADER, 16'h9000, 4, COORD_FLOOR, 0, COORD_TOP, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, COORD_FLOOR + 100, 7, COORD_TOP - 50, 1, 0));
      send_req(mk_item(OP_POINT, 0, 0, COORD_FLOOR, -1, COORD_TOP, 1, 1));
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = REG_MIN_PROB;
      csr_data        = '0;
      req.valid       = 1'b0;
      req.op          = OP_HEADER;
      req.probability = '0;
      req.class_index = '0;
      req.px          = '0;
      req.py          = '0;
      req.pz          = '0;
      req.point_valid = 1'b0;
      req.last        = 1'b0;
      req_calm        = 1'b0;
      live_items      = 0;
      quiet_cycles    = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: no class is of interest yet
      run_random(30);

      set_regs(16'h8000, 64'h7FFF_FFFF_FFFF_FFFF, 23'd100, 23'd50);
      run_directed();
      run_random(70);
      settle();
      run_random(80);

      // Widest acceptance, narrowest gates
      set_regs(16'h0000, '1, 23'd0, 23'd0);
      run_random(120);

      // Strictest probability, sparse classes, widest gates
      set_regs(16'hFFFF, 64'hAAAA_5555_0F0F_F0F0, 23'h7FFFFF, 23'h7FFFFF);
      run_random(120);

      repeat (3) begin
         set_regs(PROB_W'($urandom_range(0, 16'hC000)), {$urandom, $urandom},
                  OFFSET_W'($urandom_range(0, 4096)), OFFSET_W'($urandom_range(0, 4096)));
         run_random(90);
      end

      settle();
      repeat (8) @(negedge clock);
      if (book.pending() != 0)
         book.flag_mismatch("extents still due at end of run");
      if (book.mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== depth_gated_box_extent_top.f =====
src/dgbe_pkg.sv
src/dgbe_if.sv
src/dgbe_csr.sv
src/dgbe_extent.sv
src/depth_gated_box_extent_top.sv
test/tb.sv
